FILE: rtl/qcvp_pkg.sv
// qcvp_pkg: widths, reset values, register indexes and shared types for the
// quaternion cube vertex projector. No dependencies.
package qcvp_pkg;

   localparam int QUAT_FRAC_BITS = 14;

   localparam int QUAT_W = 16;
   localparam int PRD_W  = 2 * QUAT_W;
   localparam int TERM_W = PRD_W + 1;
   localparam int SUM_W  = TERM_W + 2;
   localparam int HALF_W = 7;
   localparam int CTR_W  = 10;
   localparam int SCR_W  = 12;
   localparam int IDX_W  = 3;
   localparam int NUM_CORNERS = 1 << IDX_W;

   localparam int SCL_W = SUM_W + HALF_W + 1;
   localparam int SHIFT = 2 * QUAT_FRAC_BITS - 1;
   localparam int EXT_W = (SHIFT + 2 > SCL_W) ? SHIFT + 2 : SCL_W;
   localparam int Q_W   = EXT_W - SHIFT;
   localparam int S_W   = ((Q_W > HALF_W + 1) ? Q_W : HALF_W + 1) + 1;
   localparam int SAT_W = ((S_W > CTR_W + 1) ? S_W : CTR_W + 1) + 1;

   localparam int SCR_MIN = -(1 << (SCR_W - 1));
   localparam int SCR_MAX = (1 << (SCR_W - 1)) - 1;

   localparam int REQ_W = 4 * QUAT_W;
   localparam int RSP_W = ((IDX_W + 2 * SCR_W + 7) / 8) * 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = CTR_W;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y  = 2'd2;

   localparam logic [HALF_W-1:0] RST_HALF_SIZE = 7'd60;
   localparam logic [CTR_W-1:0]  RST_ORIGIN_X  = 10'd160;
   localparam logic [CTR_W-1:0]  RST_ORIGIN_Y  = 10'd120;

   localparam logic [IDX_W-1:0] LAST_CORNER = IDX_W'(NUM_CORNERS - 1);

   // rows x and y of the conjugate rotation matrix, 2F fraction bits, halved
   typedef struct packed {
      logic signed [TERM_W-1:0] a00;
      logic signed [TERM_W-1:0] a01;
      logic signed [TERM_W-1:0] a02;
      logic signed [TERM_W-1:0] a10;
      logic signed [TERM_W-1:0] a11;
      logic signed [TERM_W-1:0] a12;
   } qcvp_mtx_type;

endpackage

FILE: rtl/qcvp_matrix.sv
// qcvp_matrix: three-stage pipeline from a quaternion request to the matrix
// terms, held in the last stage until the corner stage takes them.
// Depends on qcvp_pkg.
module qcvp_matrix (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [qcvp_pkg::REQ_W-1:0]     req_tdata,
   output logic                           mtx_valid,
   input  logic                           mtx_take,
   output qcvp_pkg::qcvp_mtx_type         mtx
);

   localparam int QW = qcvp_pkg::QUAT_W;
   localparam int PW = qcvp_pkg::PRD_W;
   localparam int TW = qcvp_pkg::TERM_W;

   logic m1_valid_ff, m2_valid_ff, m3_valid_ff;
   logic m1_rdy, m2_rdy, m3_rdy;

   logic signed [QW-1:0] w_ff, x_ff, y_ff, z_ff;
   logic signed [PW-1:0] xx_ff, yy_ff, zz_ff, xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic signed [PW-1:0] xx_in, yy_in, zz_in, xy_in, wz_in, xz_in, wy_in, yz_in, wx_in;
   qcvp_pkg::qcvp_mtx_type mtx_ff, mtx_in;

   assign m3_rdy     = !m3_valid_ff || mtx_take;
   assign m2_rdy     = !m2_valid_ff || m3_rdy;
   assign m1_rdy     = !m1_valid_ff || m2_rdy;
   assign req_tready = m1_rdy;
   assign mtx_valid  = m3_valid_ff;
   assign mtx        = mtx_ff;

   always_comb begin
      xx_in = x_ff * x_ff;
      yy_in = y_ff * y_ff;
      zz_in = z_ff * z_ff;
      xy_in = x_ff * y_ff;
      wz_in = w_ff * z_ff;
      xz_in = x_ff * z_ff;
      wy_in = w_ff * y_ff;
      yz_in = y_ff * z_ff;
      wx_in = w_ff * x_ff;
   end

   always_comb begin
      mtx_in.a00 = -(TW'(yy_ff) + TW'(zz_ff));
      mtx_in.a01 = TW'(xy_ff) + TW'(wz_ff);
      mtx_in.a02 = TW'(xz_ff) - TW'(wy_ff);
      mtx_in.a10 = TW'(xy_ff) - TW'(wz_ff);
      mtx_in.a11 = -(TW'(xx_ff) + TW'(zz_ff));
      mtx_in.a12 = TW'(yz_ff) + TW'(wx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else begin
         if (m1_rdy) m1_valid_ff <= req_tvalid;
         if (m2_rdy) m2_valid_ff <= m1_valid_ff;
         if (m3_rdy) m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m1_rdy) begin
         w_ff <= req_tdata[QW-1:0];
         x_ff <= req_tdata[2*QW-1:QW];
         y_ff <= req_tdata[3*QW-1:2*QW];
         z_ff <= req_tdata[4*QW-1:3*QW];
      end
      if (m2_rdy) begin
         xx_ff <= xx_in;
         yy_ff <= yy_in;
         zz_ff <= zz_in;
         xy_ff <= xy_in;
         wz_ff <= wz_in;
         xz_ff <= xz_in;
         wy_ff <= wy_in;
         yz_ff <= yz_in;
         wx_ff <= wx_in;
      end
      if (m3_rdy) mtx_ff <= mtx_in;
   end

endmodule

FILE: rtl/qcvp_corner.sv
// qcvp_corner: steps through the eight cube corners for each set of matrix
// terms and pushes them through sum, scale, truncate and project stages.
// Depends on qcvp_pkg.
module qcvp_corner (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              mtx_valid,
   output logic                              mtx_take,
   input  qcvp_pkg::qcvp_mtx_type            mtx,
   input  logic [qcvp_pkg::HALF_W-1:0]       half_size,
   input  logic [qcvp_pkg::CTR_W-1:0]        origin_x,
   input  logic [qcvp_pkg::CTR_W-1:0]        origin_y,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [qcvp_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int IW  = qcvp_pkg::IDX_W;
   localparam int SW  = qcvp_pkg::SUM_W;
   localparam int HW  = qcvp_pkg::HALF_W;
   localparam int CW  = qcvp_pkg::CTR_W;
   localparam int PW  = qcvp_pkg::SCL_W;
   localparam int EW  = qcvp_pkg::EXT_W;
   localparam int QW  = qcvp_pkg::Q_W;
   localparam int VW  = qcvp_pkg::S_W;
   localparam int AW  = qcvp_pkg::SAT_W;
   localparam int RW  = qcvp_pkg::SCR_W;
   localparam int SH  = qcvp_pkg::SHIFT;
   localparam int PAD = qcvp_pkg::RSP_W - IW - 2 * RW;

   logic c1_valid_ff, c2_valid_ff, c3_valid_ff, out_valid_ff;
   logic c1_rdy, c2_rdy, c3_rdy, out_rdy, issue;

   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] c1_idx_ff, c2_idx_ff, c3_idx_ff, out_idx_ff;

   logic signed [SW-1:0] tx_in, ty_in, tx_ff, ty_ff;
   logic signed [HW:0]   h_s, vx_in, vy_in, vx_ff, vy_ff;
   logic signed [PW-1:0] px_in, py_in, px_ff, py_ff;
   logic signed [VW-1:0] sx_in, sy_in, sx_ff, sy_ff;
   logic signed [RW-1:0] scr_x_in, scr_y_in, scr_x_ff, scr_y_ff;
   logic                 xp1, yp1, zp1, xp2, yp2;

   assign out_rdy  = !out_valid_ff || rsp_tready;
   assign c3_rdy   = !c3_valid_ff || out_rdy;
   assign c2_rdy   = !c2_valid_ff || c3_rdy;
   assign c1_rdy   = !c1_valid_ff || c2_rdy;
   assign issue    = mtx_valid && c1_rdy;
   assign mtx_take = issue && (cnt_ff == qcvp_pkg::LAST_CORNER);
   assign cnt_in   = cnt_ff + IW'(1);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = (out_idx_ff == qcvp_pkg::LAST_CORNER);
   assign rsp_tdata  = {PAD'(0), scr_y_ff, scr_x_ff, out_idx_ff};

   // corner signs: x from bit0 ^ bit1, y from bit1, z from bit2
   assign xp1 = cnt_ff[0] ^ cnt_ff[1];
   assign yp1 = cnt_ff[1];
   assign zp1 = cnt_ff[2];
   assign xp2 = c1_idx_ff[0] ^ c1_idx_ff[1];
   assign yp2 = c1_idx_ff[1];

   always_comb begin
      tx_in = (xp1 ? SW'(mtx.a00) : -SW'(mtx.a00))
            + (yp1 ? SW'(mtx.a01) : -SW'(mtx.a01))
            + (zp1 ? SW'(mtx.a02) : -SW'(mtx.a02));
      ty_in = (xp1 ? SW'(mtx.a10) : -SW'(mtx.a10))
            + (yp1 ? SW'(mtx.a11) : -SW'(mtx.a11))
            + (zp1 ? SW'(mtx.a12) : -SW'(mtx.a12));
   end

   always_comb begin
      h_s   = {1'b0, half_size};
      vx_in = xp2 ? h_s : -h_s;
      vy_in = yp2 ? h_s : -h_s;
      px_in = tx_ff * h_s;
      py_in = ty_ff * h_s;
   end

   // v + 2*h*T / 2^(2F), truncated toward zero
   function automatic logic signed [VW-1:0] trunc_coord(
      input logic signed [PW-1:0] p,
      input logic signed [HW:0]   v
   );
      logic signed [EW-1:0] p_ext;
      logic signed [QW-1:0] q;
      logic                 frac;
      logic signed [VW-1:0] s;
      p_ext = EW'(p);
      q     = p_ext[EW-1:SH];
      frac  = |p_ext[SH-1:0];
      s     = VW'(q) + VW'(v);
      if (s[VW-1] && frac) s = s + VW'(1);
      return s;
   endfunction

   assign sx_in = trunc_coord(px_ff, vx_ff);
   assign sy_in = trunc_coord(py_ff, vy_ff);

   function automatic logic signed [RW-1:0] sat_scr(input logic signed [AW-1:0] a);
      logic signed [RW-1:0] r;
      if (a < AW'(qcvp_pkg::SCR_MIN))      r = RW'(qcvp_pkg::SCR_MIN);
      else if (a > AW'(qcvp_pkg::SCR_MAX)) r = RW'(qcvp_pkg::SCR_MAX);
      else                                 r = RW'(a);
      return r;
   endfunction

   always_comb begin
      logic signed [CW:0] ox_s, oy_s;
      ox_s     = {1'b0, origin_x};
      oy_s     = {1'b0, origin_y};
      scr_x_in = sat_scr(AW'(ox_s) + AW'(sx_ff));
      scr_y_in = sat_scr(AW'(oy_s) - AW'(sy_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         c1_valid_ff  <= 1'b0;
         c2_valid_ff  <= 1'b0;
         c3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (issue)   cnt_ff       <= cnt_in;
         if (c1_rdy)  c1_valid_ff  <= issue;
         if (c2_rdy)  c2_valid_ff  <= c1_valid_ff;
         if (c3_rdy)  c3_valid_ff  <= c2_valid_ff;
         if (out_rdy) out_valid_ff <= c3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c1_rdy) begin
         c1_idx_ff <= cnt_ff;
         tx_ff     <= tx_in;
         ty_ff     <= ty_in;
      end
      if (c2_rdy) begin
         c2_idx_ff <= c1_idx_ff;
         px_ff     <= px_in;
         py_ff     <= py_in;
         vx_ff     <= vx_in;
         vy_ff     <= vy_in;
      end
      if (c3_rdy) begin
         c3_idx_ff <= c2_idx_ff;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
      end
      if (out_rdy) begin
         out_idx_ff <= c3_idx_ff;
         scr_x_ff   <= scr_x_in;
         scr_y_ff   <= scr_y_in;
      end
   end

endmodule

FILE: rtl/quaternion_cube_vertex_projector.sv
// Top level of the quaternion cube vertex projector: configuration registers,
// matrix pipeline and corner pipeline. Depends on qcvp_pkg, qcvp_matrix, qcvp_corner.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/tready      tdata: quat_w, quat_x, quat_y, quat_z
//   rsp_     out  rsp_tvalid/tready      tdata: vertex_index, screen_x, screen_y; tlast
//   csr_     in   csr_valid/ready        csr_index, csr_data
//
// One request yields eight responses, one per cycle unless rsp_ stalls; the corner
// sequencer issues one corner per cycle while not stalled, then takes the next matrix terms.
// A request passes the matrix stages, then the sum, scale, truncate and project stages.
// Up to two further requests queue in the matrix stages while corners drain.
// Reset clears the valid bits and loads half_size 60, center 160 / 120.
// Stalls on rsp_ back up stage by stage; nothing is dropped or repeated.
module quaternion_cube_vertex_projector (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [qcvp_pkg::REQ_W-1:0]        req_tdata,  // quat_w, quat_x, quat_y, quat_z
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [qcvp_pkg::RSP_W-1:0]        rsp_tdata,  // vertex_index, screen_x, screen_y
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qcvp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [qcvp_pkg::CSR_DAT_W-1:0]    csr_data
);

   logic [qcvp_pkg::HALF_W-1:0] half_size_ff;
   logic [qcvp_pkg::CTR_W-1:0]  origin_x_ff, origin_y_ff;
   logic                        mtx_valid, mtx_take;
   qcvp_pkg::qcvp_mtx_type      mtx;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_size_ff <= qcvp_pkg::RST_HALF_SIZE;
         origin_x_ff  <= qcvp_pkg::RST_ORIGIN_X;
         origin_y_ff  <= qcvp_pkg::RST_ORIGIN_Y;
      end else if (csr_valid) begin
         unique case (csr_index)
            qcvp_pkg::CSR_HALF_SIZE: half_size_ff <= csr_data[qcvp_pkg::HALF_W-1:0];
            qcvp_pkg::CSR_ORIGIN_X:  origin_x_ff  <= csr_data;
            qcvp_pkg::CSR_ORIGIN_Y:  origin_y_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   qcvp_matrix u_matrix (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .mtx_valid  (mtx_valid),
      .mtx_take   (mtx_take),
      .mtx        (mtx)
   );

   qcvp_corner u_corner (
      .clock      (clock),
      .reset      (reset),
      .mtx_valid  (mtx_valid),
      .mtx_take   (mtx_take),
      .mtx        (mtx),
      .half_size  (half_size_ff),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/qcvp_checker.sv
// qcvp_props: port-level assertions for the projector, bound to the top level.
// Depends on qcvp_pkg and quaternion_cube_vertex_projector.
module qcvp_props (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [qcvp_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                              rsp_tlast
);

   localparam int IW = qcvp_pkg::IDX_W;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[IW-1:0] == qcvp_pkg::LAST_CORNER)))
      else $error("tlast does not match the last corner");

   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         !rsp_tvalid || (rsp_tdata[IW-1:0] == $past(rsp_tdata[IW-1:0]) + IW'(1)))
      else $error("corners out of order");

endmodule

bind quaternion_cube_vertex_projector qcvp_props u_qcvp_props (.*);

FILE: bench/qcvp_checker.sv
// Checker for the quaternion cube vertex projector: watches the csr_, req_ and rsp_
// channels, predicts the eight projected corners of each request and compares them.
// Depends on qcvp_pkg.
`timescale 1ns / 1ps
module qcvp_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [qcvp_pkg::REQ_W-1:0]     req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [qcvp_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [qcvp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qcvp_pkg::CSR_DAT_W-1:0] csr_data,
   output int                             mismatches,
   output int                             corners_due
);

   localparam int IDX_W  = qcvp_pkg::IDX_W;
   localparam int SCR_W  = qcvp_pkg::SCR_W;
   localparam int QUAT_W = qcvp_pkg::QUAT_W;
   localparam int HALF_W = qcvp_pkg::HALF_W;
   localparam int CTR_W  = qcvp_pkg::CTR_W;

   typedef struct packed {
      logic [IDX_W-1:0] vertex;
      logic [SCR_W-1:0] scr_x;
      logic [SCR_W-1:0] scr_y;
      logic             last;
   } corner_type;

   corner_type        corner_q[$];
   logic [HALF_W-1:0] half_size = qcvp_pkg::RST_HALF_SIZE;
   logic [CTR_W-1:0]  ctr_x = qcvp_pkg::RST_ORIGIN_X;
   logic [CTR_W-1:0]  ctr_y = qcvp_pkg::RST_ORIGIN_Y;

   // trunc(v + s / 2^2F), toward zero, exact
   function automatic longint trunc_axis(input longint v, input longint s);
      longint scale;
      scale = longint'(1) <<< (2 * qcvp_pkg::QUAT_FRAC_BITS);
      return (v * scale + s) / scale;
   endfunction

   function automatic logic [SCR_W-1:0] clamp_screen(input longint v);
      if (v < qcvp_pkg::SCR_MIN) v = qcvp_pkg::SCR_MIN;
      else if (v > qcvp_pkg::SCR_MAX) v = qcvp_pkg::SCR_MAX;
      return v[SCR_W-1:0];
   endfunction

   function automatic void project_corners(input logic [qcvp_pkg::REQ_W-1:0] quat);
      longint     cw, cx, cy, cz, h, vx, vy, vz, sx, sy;
      longint     m00, m01, m02, m10, m11, m12;
      corner_type c;
      // conjugate: vector part negated
      cw = longint'($signed(quat[QUAT_W-1:0]));
      cx = -longint'($signed(quat[2*QUAT_W-1:QUAT_W]));
      cy = -longint'($signed(quat[3*QUAT_W-1:2*QUAT_W]));
      cz = -longint'($signed(quat[4*QUAT_W-1:3*QUAT_W]));
      h  = longint'(half_size);
      m00 = -(cy * cy + cz * cz);
      m01 = cx * cy - cw * cz;
      m02 = cw * cy + cx * cz;
      m10 = cw * cz + cx * cy;
      m11 = -(cx * cx + cz * cz);
      m12 = cy * cz - cw * cx;
      for (int i = 0; i < qcvp_pkg::NUM_CORNERS; i++) begin
         vx = (i[0] ^ i[1]) ? h : -h;
         vy = i[1] ? h : -h;
         vz = i[2] ? h : -h;
         sx = 2 * (m00 * vx + m01 * vy + m02 * vz);
         sy = 2 * (m10 * vx + m11 * vy + m12 * vz);
         c.vertex = i[IDX_W-1:0];
         c.scr_x  = clamp_screen(longint'(ctr_x) + trunc_axis(vx, sx));
         c.scr_y  = clamp_screen(longint'(ctr_y) - trunc_axis(vy, sy));
         c.last   = (i == qcvp_pkg::NUM_CORNERS - 1);
         corner_q.push_back(c);
      end
   endfunction

   task automatic report(input string what, input longint want, input longint got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      corner_type       want;
      logic [IDX_W-1:0] got_v;
      logic [SCR_W-1:0] got_x;
      logic [SCR_W-1:0] got_y;
      if (reset) begin
         half_size = qcvp_pkg::RST_HALF_SIZE;
         ctr_x = qcvp_pkg::RST_ORIGIN_X;
         ctr_y = qcvp_pkg::RST_ORIGIN_Y;
         corner_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               qcvp_pkg::CSR_HALF_SIZE: half_size = csr_data[HALF_W-1:0];
               qcvp_pkg::CSR_ORIGIN_X:  ctr_x = csr_data;
               qcvp_pkg::CSR_ORIGIN_Y:  ctr_y = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got_v = rsp_tdata[IDX_W-1:0];
            got_x = rsp_tdata[IDX_W+SCR_W-1:IDX_W];
            got_y = rsp_tdata[IDX_W+2*SCR_W-1:IDX_W+SCR_W];
            if (corner_q.size() == 0) begin
               report("unexpected corner, vertex", -1, got_v);
            end else begin
               want = corner_q.pop_front();
               if (got_v != want.vertex) report("vertex_index", want.vertex, got_v);
               if (got_x != want.scr_x)
                  report("screen_x", $signed(want.scr_x), $signed(got_x));
               if (got_y != want.scr_y)
                  report("screen_y", $signed(want.scr_y), $signed(got_y));
               if (rsp_tlast !== want.last) report("last", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) project_corners(req_tdata);
      end
      corners_due = corner_q.size();
   end

endmodule

FILE: bench/tb_quaternion_cube_vertex_projector.sv
// Testbench top for the quaternion cube vertex projector: clock, reset, request,
// response-stall and register stimulus, and the verdict. Depends on qcvp_pkg, qcvp_checker.
`timescale 1ns / 1ps
module tb_quaternion_cube_vertex_projector;

   localparam int QUAT_W    = qcvp_pkg::QUAT_W;
   localparam int CSR_IDX_W = qcvp_pkg::CSR_IDX_W;
   localparam int CSR_DAT_W = qcvp_pkg::CSR_DAT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int QUATS_PER_PHASE = 50;
   localparam int HOLD_CYCLES = 90;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [qcvp_pkg::REQ_W-1:0]    req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [qcvp_pkg::RSP_W-1:0]    rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DAT_W-1:0]          csr_data = '0;

   bit idle_on = 1'b1;
   bit hold_rsp = 1'b0;
   int mismatches;
   int corners_due;

   quaternion_cube_vertex_projector uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   qcvp_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .corners_due (corners_due)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(200_000 * 12);
      $display("status: fail");
      $finish;
   end

   task automatic send_quat(input logic [QUAT_W-1:0] w, x, y, z);
      if (idle_on && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x, w};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (corners_due != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_regs(input logic [CSR_DAT_W-1:0] half, cx, cy, input bit spare);
      write_reg(qcvp_pkg::CSR_HALF_SIZE, half);
      write_reg(qcvp_pkg::CSR_ORIGIN_X, cx);
      write_reg(qcvp_pkg::CSR_ORIGIN_Y, cy);
      if (spare) write_reg(CSR_SPARE, CSR_DAT_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [QUAT_W-1:0] pick_component();
      int sel;
      sel = $urandom_range(9);
      if (sel < 7) return QUAT_W'($urandom_range(32768) - 16384);
      else if (sel < 9) return QUAT_W'($urandom);
      else return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_quat(pick_component(), pick_component(), pick_component(),
                               pick_component());
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      wait (!reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(8, 1)) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values
      send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
      send_quat(16'hC000, 16'h0000, 16'h0000, 16'h0000);
      send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
      send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
      send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
      send_quat(16'h2D41, 16'h0000, 16'h0000, 16'h2D41);
      send_quat(16'h2D41, 16'h2D41, 16'h0000, 16'h0000);
      send_quat(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000);
      send_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000);
      send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
      send_quat(16'hC000, 16'hC000, 16'hC000, 16'hC000);
      send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_quat(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
      drain();

      // largest cube, far corner of the screen
      program_regs(10'd127, 10'd1023, 10'd1023, 1'b0);
      send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
      send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      drain();

      // largest cube at the origin
      program_regs(10'd127, 10'd0, 10'd0, 1'b1);
      send_quat(16'h2D41, 16'h0000, 16'h0000, 16'hD2BF);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      drain();

      // degenerate cube
      program_regs(10'd0, 10'd512, 10'd512, 1'b0);
      send_quat(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
      send_quat(16'h2000, 16'hE000, 16'h2000, 16'hE000);
      drain();

      for (int p = 0; p < 5; p++) begin
         if (p == 4) idle_on = 1'b0;
         program_regs(CSR_DAT_W'($urandom), CSR_DAT_W'($urandom), CSR_DAT_W'($urandom),
                      p == 2);
         if (p == 1) begin
            // back up the pipe: sender keeps pushing while responses are held off
            idle_on = 1'b0;
            hold_rsp = 1'b1;
            send_random(16);
            idle_on = 1'b1;
            send_random(QUATS_PER_PHASE - 16);
         end else begin
            send_random(QUATS_PER_PHASE);
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && corners_due == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
